// ===== design/sasmd_pkg.sv =====
// Shared types and constants for the signed add/sub/mul/div unit.
// No dependencies.
`default_nettype none
package sasmd_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int MAG_WIDTH  = DATA_WIDTH - 1;
    localparam int N_STAGES   = DATA_WIDTH;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    // data handed from cell to cell
    typedef struct packed {
        logic  valid;
        mode_t mode;
        word_t res;     // finished result for add/sub/mul
        word_t rem;     // partial remainder (division)
        word_t quo;     // dividend bits shifting out, quotient bits shifting in
        word_t dvs;     // divisor magnitude
        logic  neg;     // negate quotient at the end
        logic  dz;      // divide by zero
    } cell_t;
endpackage
`default_nettype wire

// ===== design/sasmd_cell.sv =====
// One restoring-division cell: one quotient bit per cycle; other modes pass.
// Depends on sasmd_pkg.
`default_nettype none
module sasmd_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sasmd_pkg::cell_t  din,
    output sasmd_pkg::cell_t       dout
);
    sasmd_pkg::cell_t cell_reg, cell_next;
    logic [sasmd_pkg::DATA_WIDTH:0] trial;
    sasmd_pkg::word_t               shifted;

    always_comb
    begin
        cell_next = din;
        shifted = {din.rem[sasmd_pkg::DATA_WIDTH-2:0], din.quo[sasmd_pkg::DATA_WIDTH-1]};
        trial = {1'b0, shifted} - {1'b0, din.dvs};
        if (din.mode == sasmd_pkg::MODE_DIV)
        begin
            if (!trial[sasmd_pkg::DATA_WIDTH])
            begin
                cell_next.rem = trial[sasmd_pkg::DATA_WIDTH-1:0];
                cell_next.quo = {din.quo[sasmd_pkg::DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                cell_next.rem = shifted;
                cell_next.quo = {din.quo[sasmd_pkg::DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else
            cell_reg <= cell_next;
    end

    assign dout = cell_reg;
endmodule
`default_nettype wire

// ===== design/signed_add_sub_mul_div_unit.sv =====
// Top level of the signed add/sub/mul/div unit: entry stage, cell row, exit stage.
// Depends on sasmd_pkg and sasmd_cell.
//
// Usage: drive mode, operand_a, operand_b and pulse start; a request is taken
// on every edge where start is high and busy is low. busy is tied low, so one
// request per cycle is accepted in every mode.
// Every mode goes through the same row: one entry register, 32 division
// cells (one quotient bit each), one exit register. done rises once a
// request has passed the entry register, every cell and the exit register,
// for all modes, so results leave in request order.
// Throughput is one per cycle.
// result_value is valid only in the cycle done is high; the receiver cannot
// stall and must take it then.
// Reset clears the entry register, every cell and done, but not the result register; requests in flight are dropped.
`default_nettype none
module signed_add_sub_mul_div_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic signed [sasmd_pkg::DATA_WIDTH-1:0] operand_a,
    input  wire logic signed [sasmd_pkg::DATA_WIDTH-1:0] operand_b,
    output logic             done,
    output logic signed [sasmd_pkg::DATA_WIDTH-1:0] result_value
);
    localparam int W = sasmd_pkg::DATA_WIDTH;

    sasmd_pkg::cell_t entry_reg, entry_next;
    sasmd_pkg::cell_t chain [0:sasmd_pkg::N_STAGES];
    sasmd_pkg::word_t a_mag, b_mag, prod, q;
    logic             done_reg, done_next;
    sasmd_pkg::word_t result_reg, result_next;

    assign busy = 1'b0;

    always_comb
    begin
        a_mag = operand_a[W-1] ? (~operand_a + 1'b1) : operand_a;
        b_mag = operand_b[W-1] ? (~operand_b + 1'b1) : operand_b;
        prod  = operand_a * operand_b;
        entry_next.valid = start;
        entry_next.mode  = sasmd_pkg::mode_t'(mode);
        entry_next.rem   = '0;
        entry_next.quo   = a_mag;
        entry_next.dvs   = b_mag;
        entry_next.neg   = operand_a[W-1] ^ operand_b[W-1];
        entry_next.dz    = (operand_b == '0);
        case (sasmd_pkg::mode_t'(mode))
            sasmd_pkg::MODE_ADD: entry_next.res = operand_a + operand_b;
            sasmd_pkg::MODE_SUB: entry_next.res = operand_a - operand_b;
            sasmd_pkg::MODE_MUL: entry_next.res = prod;
            default:             entry_next.res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

    assign chain[0] = entry_reg;

    for (genvar i = 0; i < sasmd_pkg::N_STAGES; i++)
    begin : g_cell
        sasmd_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (chain[i]),
            .dout (chain[i+1])
        );
    end

    always_comb
    begin
        q = chain[sasmd_pkg::N_STAGES].neg ? (~chain[sasmd_pkg::N_STAGES].quo + 1'b1)
                                          : chain[sasmd_pkg::N_STAGES].quo;
        done_next = chain[sasmd_pkg::N_STAGES].valid;
        if (chain[sasmd_pkg::N_STAGES].mode != sasmd_pkg::MODE_DIV)
            result_next = chain[sasmd_pkg::N_STAGES].res;
        else if (chain[sasmd_pkg::N_STAGES].dz)
            result_next = {1'b0, {sasmd_pkg::MAG_WIDTH{1'b1}}};
        else
            result_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done         = done_reg;
    assign result_value = result_reg;
endmodule
`default_nettype wire

// ===== sim/tb_signed_add_sub_mul_div_unit.sv =====
// Testbench for the signed add/sub/mul/div unit: directed corner requests, then random ones,
// each result checked in order against a local arithmetic predictor.
// Depends on sasmd_pkg and signed_add_sub_mul_div_unit.
`default_nettype none
module tb_signed_add_sub_mul_div_unit;
    localparam int LATENCY     = 34;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7fff_ffff;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] mode = sasmd_pkg::MODE_ADD;
    logic signed [31:0] operand_a = '0;
    logic signed [31:0] operand_b = '0;
    logic busy;
    logic done;
    logic signed [31:0] result_value;

    logic [31:0] pending_results[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int cycles = 0;
    bit allow_gaps = 1'b1;

    signed_add_sub_mul_div_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .operand_a(operand_a), .operand_b(operand_b), .done(done),
        .result_value(result_value)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] arith_result(sasmd_pkg::mode_t m, logic [31:0] a,
                                                 logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [63:0] p;
        case (m)
            sasmd_pkg::MODE_ADD: return a + b;
            sasmd_pkg::MODE_SUB: return a - b;
            sasmd_pkg::MODE_MUL:
            begin
                p = {32'd0, a} * {32'd0, b};
                return p[31:0];
            end
            default:
            begin
                if (b == 32'd0)
                    return MOST_POS;
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb;
                return (a[31] ^ b[31]) ? -q : q;
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("signed_add_sub_mul_div_unit verification failed");
            $finish;
        end
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, result_value);
                errors++;
            end
            else
            begin
                if (pending_results[0] !== result_value)
                begin
                    $display("%0t result mismatch: expected %h, actual %h",
                             $time, pending_results[0], result_value);
                    errors++;
                end
                void'(pending_results.pop_front());
                checked++;
            end
        end
    end

    // Drives one request and holds it until taken; start stays high across back-to-back requests.
    task automatic send_request(sasmd_pkg::mode_t m, logic [31:0] a, logic [31:0] b);
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_results.push_back(arith_result(m, a, b));
        sent++;
    endtask

    task automatic release_start();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(0, 20) - 10;
            5: return $urandom & 32'h0000_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_corners();
        logic [31:0] edge_vals[6];
        edge_vals = '{MOST_NEG, MOST_POS, 32'hffff_ffff, 32'd0, 32'd1, 32'h5555_aaaa};
        foreach (edge_vals[i])
            send_request(sasmd_pkg::MODE_ADD, edge_vals[i], edge_vals[(i + 1) % 6]);
        send_request(sasmd_pkg::MODE_SUB, MOST_NEG, 32'd1);
        send_request(sasmd_pkg::MODE_SUB, 32'd0, MOST_NEG);
        send_request(sasmd_pkg::MODE_MUL, MOST_NEG, 32'hffff_ffff);
        send_request(sasmd_pkg::MODE_MUL, MOST_POS, MOST_POS);
        send_request(sasmd_pkg::MODE_MUL, 32'hffff_fffd, 32'd7);
        // divide by zero, overflow, most-negative divisor, sign mixes
        send_request(sasmd_pkg::MODE_DIV, 32'd17, 32'd0);
        send_request(sasmd_pkg::MODE_DIV, MOST_NEG, 32'd0);
        send_request(sasmd_pkg::MODE_DIV, MOST_NEG, 32'hffff_ffff);
        send_request(sasmd_pkg::MODE_DIV, MOST_NEG, MOST_NEG);
        send_request(sasmd_pkg::MODE_DIV, MOST_POS, MOST_NEG);
        send_request(sasmd_pkg::MODE_DIV, 32'hffff_fff9, 32'd2);
        send_request(sasmd_pkg::MODE_DIV, 32'd7, 32'hffff_fffe);
        send_request(sasmd_pkg::MODE_DIV, 32'hffff_fff9, 32'hffff_fffe);
        send_request(sasmd_pkg::MODE_DIV, MOST_POS, 32'd1);
        release_start();
    endtask

    task automatic test_random_ops(int count);
        repeat (count)
            send_request(sasmd_pkg::mode_t'($urandom_range(0, 3)), pick_operand(),
                         pick_operand());
        release_start();
    endtask

    task automatic test_back_to_back(int count);
        allow_gaps = 1'b0;
        repeat (count)
            send_request(sasmd_pkg::mode_t'($urandom_range(0, 3)), $urandom, $urandom);
        release_start();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_random_ops(350);
        test_back_to_back(100);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        $display("Sent %0d requests over all four modes, %0d results checked.", sent, checked);
        if (errors == 0)
            $display("signed_add_sub_mul_div_unit verification clean");
        else
            $display("signed_add_sub_mul_div_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== signed_add_sub_mul_div_unit.f =====
design/sasmd_pkg.sv
design/sasmd_cell.sv
design/signed_add_sub_mul_div_unit.sv
sim/tb_signed_add_sub_mul_div_unit.sv
